/* rtl/tsc_pkg.sv */
// Package for the trajectory smoothing corrector.
// Sizes, sequencer states and shared types; no dependencies.
package tsc_pkg;
  localparam int MaxRadius  = 32;
  localparam int SampleBits = 32;
  localparam int PathBits   = SampleBits + 16;
  localparam int SumBits    = PathBits + 8;
  localparam int WinDepth   = 2 * MaxRadius + 1;
  localparam int DlyDepth   = MaxRadius + 1;
  localparam int WinAw      = $clog2(WinDepth);
  localparam int DlyAw      = $clog2(DlyDepth);
  localparam int RadBits    = $clog2(MaxRadius + 1);
  localparam int CntBits    = $clog2(WinDepth + 1);
  localparam int DivSteps   = SumBits;
  localparam logic [5:0] RadiusReset = 6'd30;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [PathBits-1:0]   path_t;
  typedef logic signed [SumBits-1:0]    sum_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_PLAN, ST_SUM_RD, ST_SUM_ACC, ST_DIV,
    ST_FIX_RD, ST_FIX, ST_OUT, ST_NEXT
  } state_t;

  function automatic logic [RadBits-1:0] clamp_radius(input logic [5:0] v);
    if (v == 6'd0) return RadBits'(1);
    if (32'(v) > MaxRadius) return RadBits'(MaxRadius);
    return RadBits'(v);
  endfunction
endpackage

/* rtl/tsc_in_if.sv */
// Input channel: valid/ready with one frame delta as payload.
// Depends on tsc_pkg.
interface tsc_in_if import tsc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t delta_x;
  sample_t delta_y;
  sample_t delta_angle;
  logic    is_final;
  modport source (output valid, delta_x, delta_y, delta_angle, is_final, input ready);
  modport sink (input valid, delta_x, delta_y, delta_angle, is_final, output ready);
endinterface

/* rtl/tsc_out_if.sv */
// Output channel: valid/ready with one corrected frame as payload.
// Depends on tsc_pkg.
interface tsc_out_if import tsc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t fixed_x;
  sample_t fixed_y;
  sample_t fixed_angle;
  logic    end_of_run;
  modport source (output valid, fixed_x, fixed_y, fixed_angle, end_of_run, input ready);
  modport sink (input valid, fixed_x, fixed_y, fixed_angle, end_of_run, output ready);
endinterface

/* rtl/tsc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tsc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/trajectory_smoothing_corrector.sv */
// Trajectory smoothing corrector: accumulates frame deltas into a trajectory,
// smooths it with a centered moving average and emits delta + smoothed - path.
// Depends on tsc_pkg, tsc_in_if, tsc_out_if and tsc_ram.
//
// One frame at a time; the input is not ready until the frame is done. A word
// that emits nothing goes through accept, write and plan. Each emitted word
// reads and adds each window entry for the window sums (one RAM port per
// axis, axes in turn), passes each axis through the shared one-bit-per-cycle
// restoring divider, then reads, forms, hands over and advances, waiting
// while the receiver stalls. The final word emits up to radius+1 words
// back to back through the same loop. Window and delay history live in
// circular RAMs; no clearing pass after reset.
module trajectory_smoothing_corrector import tsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tsc_in_if.sink      in_ch,
  tsc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata
);
  state_t state_r, state_nxt;
  logic [RadBits-1:0] radius_r;
  path_t  path_r [3];
  sample_t dlt_r [3];
  logic   final_r;
  logic [31:0] taken_r;
  logic [WinAw-1:0] whead_r;
  logic [DlyAw-1:0] dhead_r;
  logic [RadBits-1:0] age_r;
  logic [CntBits-1:0] lo_r, hi_r, k_r, cnt_r;
  logic [1:0] ax_r;
  sum_t acc_r;
  logic [SumBits-1:0] mag_r, quo_r;
  logic [SumBits:0] rem_r;
  logic neg_r;
  logic [6:0] step_r;
  sum_t sm_r [3];
  sample_t fix_r [3];
  logic last_r;

  // RAM ports, one per axis for window, one per axis for delays
  logic we_w, we_d;
  logic [WinAw-1:0] wraddr;
  logic [DlyAw-1:0] draddr;
  path_t wrd [3];
  sample_t drd [3];

  for (genvar c = 0; c < 3; c++) begin : g_ram
    path_t wwd;
    sample_t dwd;
    always_comb begin
      wwd = path_r[c];
      dwd = dlt_r[c];
    end
    tsc_ram #(.Width(PathBits), .Depth(WinDepth)) u_win (
      .clk, .we(we_w), .waddr(whead_r), .wdata(wwd), .raddr(wraddr), .rdata(wrd[c]));
    tsc_ram #(.Width(SampleBits), .Depth(DlyDepth)) u_dly (
      .clk, .we(we_d), .waddr(dhead_r), .wdata(dwd), .raddr(draddr), .rdata(drd[c]));
  end

  function automatic path_t sat_path(input logic signed [PathBits:0] v);
    if (v > (PathBits+1)'($signed({1'b0, {(PathBits-1){1'b1}}})))
      return {1'b0, {(PathBits-1){1'b1}}};
    if (v < (PathBits+1)'($signed({1'b1, {(PathBits-1){1'b0}}})))
      return {1'b1, {(PathBits-1){1'b0}}};
    return PathBits'(v);
  endfunction

  function automatic sample_t sat_smp(input sum_t v);
    if (v > SumBits'($signed({1'b0, {(SampleBits-1){1'b1}}})))
      return {1'b0, {(SampleBits-1){1'b1}}};
    if (v < SumBits'($signed({1'b1, {(SampleBits-1){1'b0}}})))
      return {1'b1, {(SampleBits-1){1'b0}}};
    return SampleBits'(v);
  endfunction

  // window address: index k back from newest
  logic [WinAw:0] wsub;
  logic [CntBits-1:0] kk;
  logic [DlyAw:0] dsub;
  always_comb begin
    kk = (state_r == ST_FIX_RD) ? CntBits'(age_r) : k_r;
    wsub = {1'b0, whead_r} - (WinAw+1)'(kk) - (WinAw+1)'(1);
    if (wsub[WinAw]) wsub = wsub + (WinAw+1)'(WinDepth);
    dsub = {1'b0, dhead_r} - (DlyAw+1)'(age_r) - (DlyAw+1)'(1);
    if (dsub[DlyAw]) dsub = dsub + (DlyAw+1)'(DlyDepth);
    wraddr = wsub[WinAw-1:0];
    draddr = dsub[DlyAw-1:0];
    we_w = state_r == ST_WRITE;
    we_d = state_r == ST_WRITE;
  end

  logic [31:0] top_c;
  logic [CntBits-1:0] hi_c;
  logic [SumBits:0] trial;
  always_comb begin
    top_c = taken_r - 32'd1;
    if (top_c > 32'(radius_r)) top_c = 32'(radius_r);
    hi_c = CntBits'(age_r) + CntBits'(radius_r);
    if (32'(hi_c) > taken_r - 32'd1) hi_c = CntBits'(taken_r - 32'd1);
    trial = {rem_r[SumBits-1:0], mag_r[SumBits-1]} - {1'b0, SumBits'(cnt_r)};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_ch.valid) state_nxt = ST_WRITE;
      ST_WRITE:   state_nxt = ST_PLAN;
      ST_PLAN:    if (final_r || taken_r > 32'(radius_r)) state_nxt = ST_SUM_RD;
                  else state_nxt = ST_IDLE;
      ST_SUM_RD:  state_nxt = ST_SUM_ACC;
      ST_SUM_ACC: if (k_r == hi_r) state_nxt = ST_DIV;
                  else state_nxt = ST_SUM_RD;
      ST_DIV:     if (step_r == 7'(DivSteps + 1)) begin
                    if (ax_r == 2'd2) state_nxt = ST_FIX_RD;
                    else state_nxt = ST_SUM_RD;
                  end
      ST_FIX_RD:  state_nxt = ST_FIX;
      ST_FIX:     state_nxt = ST_OUT;
      ST_OUT:     if (out_ch.ready) state_nxt = last_r || !final_r ? ST_NEXT : ST_NEXT;
      ST_NEXT:    if (final_r && age_r != '0) state_nxt = ST_SUM_RD;
                  else state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = state_r == ST_IDLE;
    out_ch.valid = state_r == ST_OUT;
    out_ch.fixed_x = fix_r[0];
    out_ch.fixed_y = fix_r[1];
    out_ch.fixed_angle = fix_r[2];
    out_ch.end_of_run = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      radius_r <= clamp_radius(RadiusReset);
      for (int c = 0; c < 3; c++) path_r[c] <= '0;
      taken_r <= '0;
      whead_r <= '0;
      dhead_r <= '0;
      final_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && taken_r == '0 && state_r == ST_IDLE) radius_r <= clamp_radius(cfg_wdata);
      unique case (state_r)
        ST_IDLE: if (in_ch.valid) begin
          path_r[0] <= sat_path(PathBits'(path_r[0]) + (PathBits+1)'(in_ch.delta_x));
          path_r[1] <= sat_path(PathBits'(path_r[1]) + (PathBits+1)'(in_ch.delta_y));
          path_r[2] <= sat_path(PathBits'(path_r[2]) + (PathBits+1)'(in_ch.delta_angle));
          dlt_r[0] <= in_ch.delta_x;
          dlt_r[1] <= in_ch.delta_y;
          dlt_r[2] <= in_ch.delta_angle;
          final_r <= in_ch.is_final;
          if (taken_r != '1) taken_r <= taken_r + 32'd1;
        end
        ST_WRITE: begin
          whead_r <= (whead_r == WinAw'(WinDepth - 1)) ? '0 : whead_r + WinAw'(1);
          dhead_r <= (dhead_r == DlyAw'(DlyDepth - 1)) ? '0 : dhead_r + DlyAw'(1);
        end
        ST_PLAN: begin
          age_r <= final_r ? RadBits'(top_c) : radius_r;
          last_r <= final_r && top_c == '0;
          ax_r <= '0;
          lo_r <= '0;
          k_r <= '0;
          hi_r <= '0;
          acc_r <= '0;
        end
        ST_SUM_RD: if (k_r == lo_r) begin
          // first read of an axis: set window bounds
          lo_r <= (age_r > radius_r) ? CntBits'(age_r - radius_r) : '0;
          hi_r <= hi_c;
          k_r <= (age_r > radius_r) ? CntBits'(age_r - radius_r) : '0;
          cnt_r <= hi_c - ((age_r > radius_r) ? CntBits'(age_r - radius_r) : '0)
                   + CntBits'(1);
          acc_r <= '0;
        end
        ST_SUM_ACC: begin
          acc_r <= acc_r + SumBits'(wrd[ax_r]);
          if (k_r != hi_r) k_r <= k_r + CntBits'(1);
          step_r <= '0;
        end
        ST_DIV: begin
          if (step_r == '0) begin
            neg_r <= acc_r[SumBits-1];
            mag_r <= (acc_r[SumBits-1] ? -acc_r : acc_r) + SumBits'(cnt_r >> 1);
            rem_r <= '0;
            quo_r <= '0;
          end else if (step_r <= 7'(DivSteps)) begin
            mag_r <= mag_r << 1;
            if (!trial[SumBits]) begin
              rem_r <= trial;
              quo_r <= {quo_r[SumBits-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[SumBits-1:0], mag_r[SumBits-1]};
              quo_r <= {quo_r[SumBits-2:0], 1'b0};
            end
          end else begin
            sm_r[ax_r] <= neg_r ? -sum_t'(quo_r) : sum_t'(quo_r);
            ax_r <= ax_r + 2'd1;
            k_r <= lo_r;
          end
          step_r <= step_r + 7'd1;
        end
        ST_FIX: for (int c = 0; c < 3; c++)
          fix_r[c] <= sat_smp(SumBits'(drd[c]) + sm_r[c] - SumBits'(wrd[c]));
        ST_NEXT: begin
          ax_r <= '0;
          lo_r <= '0;
          k_r <= '0;
          if (final_r && age_r != '0) begin
            age_r <= age_r - RadBits'(1);
            last_r <= age_r == RadBits'(1);
          end else if (final_r) begin
            for (int c = 0; c < 3; c++) path_r[c] <= '0;
            taken_r <= '0;
            final_r <= 1'b0;
            last_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench for trajectory_smoothing_corrector: random and directed frame-delta
// sequences, checked word by word against an in-bench smoothing predictor.
// Depends on tsc_pkg, tsc_in_if, tsc_out_if and the block's RTL.
module tb;
  import tsc_pkg::*;

  typedef struct {
    sample_t dx;
    sample_t dy;
    sample_t da;
    logic    fin;
  } frame_t;

  typedef struct {
    sample_t fx;
    sample_t fy;
    sample_t fa;
    logic    eor;
  } fixed_t;

  localparam longint PathHi = (64'sd1 <<< (PathBits - 1)) - 1;
  localparam longint SampHi = (64'sd1 <<< (SampleBits - 1)) - 1;
  localparam int     CycleLimit = 3000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [5:0] cfg_wdata;

  tsc_in_if  in_ch ();
  tsc_out_if out_ch ();

  trajectory_smoothing_corrector uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  frame_t frames_to_send[$];
  fixed_t fixed_expected[$];
  frame_t frame_on_bus;

  int  mismatch_count;
  int  cycle_count;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_request;
  int  hold_seen;
  int  hold_left;

  int     smooth_radius;
  longint trail[3];
  longint trail_hist[3][WinDepth];
  longint delta_hist[3][DlyDepth];
  int     frames_in_run;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL trajectory_smoothing_corrector");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  function automatic int clamp_to_radius(input logic [5:0] v);
    if (v == 6'd0) return 1;
    if (int'(v) > MaxRadius) return MaxRadius;
    return int'(v);
  endfunction

  function automatic longint saturate(input longint v, input longint hi);
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint round_mean(input longint s, input longint n);
    longint m;
    longint q;
    m = (s < 0) ? -s : s;
    q = (m + n / 2) / n;
    return (s < 0) ? -q : q;
  endfunction

  function automatic void correct_frame(input int age, input logic last);
    int     lo;
    int     hi;
    longint s;
    longint r[3];
    fixed_t w;
    lo = (age > smooth_radius) ? age - smooth_radius : 0;
    hi = age + smooth_radius;
    if (hi > frames_in_run - 1) hi = frames_in_run - 1;
    for (int c = 0; c < 3; c++) begin
      s = 0;
      for (int k = lo; k <= hi; k++) s += trail_hist[c][k];
      r[c] = saturate(delta_hist[c][age] + round_mean(s, hi - lo + 1) - trail_hist[c][age],
                      SampHi);
    end
    w.fx  = sample_t'(r[0]);
    w.fy  = sample_t'(r[1]);
    w.fa  = sample_t'(r[2]);
    w.eor = last;
    fixed_expected = {fixed_expected, w};
  endfunction

  function automatic void smooth_frame(input frame_t f);
    longint d[3];
    int     top;
    d[0] = longint'(f.dx);
    d[1] = longint'(f.dy);
    d[2] = longint'(f.da);
    for (int c = 0; c < 3; c++) begin
      for (int k = WinDepth - 1; k > 0; k--) trail_hist[c][k] = trail_hist[c][k-1];
      for (int k = DlyDepth - 1; k > 0; k--) delta_hist[c][k] = delta_hist[c][k-1];
      trail[c] = saturate(trail[c] + d[c], PathHi);
      trail_hist[c][0] = trail[c];
      delta_hist[c][0] = d[c];
    end
    frames_in_run++;
    if (f.fin) begin
      top = frames_in_run - 1;
      if (top > smooth_radius) top = smooth_radius;
      for (int a = top; a >= 0; a--) correct_frame(a, a == 0);
      for (int c = 0; c < 3; c++) trail[c] = 0;
      frames_in_run = 0;
    end else if (frames_in_run > smooth_radius) begin
      correct_frame(smooth_radius, 1'b0);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.delta_x     <= '0;
      in_ch.delta_y     <= '0;
      in_ch.delta_angle <= '0;
      in_ch.is_final    <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) smooth_frame(frame_on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (frames_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          frame_on_bus       = frames_to_send.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.delta_x     <= frame_on_bus.dx;
          in_ch.delta_y     <= frame_on_bus.dy;
          in_ch.delta_angle <= frame_on_bus.da;
          in_ch.is_final    <= frame_on_bus.fin;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    fixed_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (fixed_expected.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = fixed_expected.pop_front();
          if (out_ch.fixed_x !== want.fx) report_mismatch("fixed_x", out_ch.fixed_x, want.fx);
          if (out_ch.fixed_y !== want.fy) report_mismatch("fixed_y", out_ch.fixed_y, want.fy);
          if (out_ch.fixed_angle !== want.fa)
            report_mismatch("fixed_angle", out_ch.fixed_angle, want.fa);
          if (out_ch.end_of_run !== want.eor)
            report_mismatch("end_of_run", out_ch.end_of_run, want.eor);
        end
      end
      if (hold_seen != hold_request) begin
        hold_seen = hold_request;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic sample_t pick_delta();
    case ($urandom_range(7))
      0: return sample_t'(32'h7fffffff);
      1: return sample_t'(32'h80000000);
      2, 3: return sample_t'($urandom);
      default: return sample_t'($signed($urandom_range(32'h1fffff)) - 32'sh100000);
    endcase
  endfunction

  task automatic wait_drained();
    while (frames_to_send.size() > 0 || in_ch.valid || fixed_expected.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_radius(input logic [5:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    smooth_radius = clamp_to_radius(v);
  endtask

  task automatic queue_run(input int len, input bit fixed_pattern);
    frame_t f;
    for (int i = 0; i < len; i++) begin
      if (fixed_pattern) begin
        case (i % 3)
          0: f.dx = sample_t'(32'h7fffffff);
          1: f.dx = sample_t'(32'h80000000);
          default: f.dx = '0;
        endcase
        f.dy = -f.dx;
        f.da = f.dx;
      end else begin
        f.dx = pick_delta();
        f.dy = pick_delta();
        f.da = pick_delta();
      end
      f.fin = (i == len - 1);
      frames_to_send = {frames_to_send, f};
    end
  endtask

  initial begin
    int sent;
    int len;
    bit held;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    mismatch_count = 0;
    cycle_count   = 0;
    hold_request  = 0;
    hold_seen     = 0;
    hold_left     = 0;
    send_idle_pct = 18;
    recv_idle_pct = 58;
    smooth_radius = clamp_to_radius(RadiusReset);
    frames_in_run = 0;
    for (int c = 0; c < 3; c++) trail[c] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_run(3, 1'b1);
    wait_drained();
    set_radius(6'd1);
    queue_run(6, 1'b1);
    wait_drained();
    set_radius(6'd0);
    queue_run(1, 1'b0);
    wait_drained();
    set_radius(6'd63);
    queue_run(4, 1'b0);
    wait_drained();
    set_radius(6'd33);
    queue_run(2, 1'b1);
    wait_drained();

    sent = 0;
    held = 1'b0;
    while (sent < 84) begin
      if (sent >= 33 && sent < 66) begin
        send_idle_pct = 58;
        recv_idle_pct = 18;
      end else if (sent >= 66) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(3) == 0) set_radius(6'($urandom_range(32, 1)));
      else set_radius(6'($urandom_range(6, 1)));
      len = $urandom_range(smooth_radius + 8, 1);
      if (!held && sent >= 20) begin
        set_radius(6'd32);
        len = 40;
        held = 1'b1;
        hold_request++;
      end else if (len > 84 - sent) begin
        len = 84 - sent;
      end
      queue_run(len, 1'b0);
      sent += len;
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("PASS trajectory_smoothing_corrector");
    end else begin
      $display("FAIL trajectory_smoothing_corrector");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/tsc_pkg.sv
rtl/tsc_in_if.sv
rtl/tsc_out_if.sv
rtl/tsc_ram.sv
rtl/trajectory_smoothing_corrector.sv
tb/sv/tb.sv
